### rtl/core/ntpc_pkg.sv
// ----------------------------------------------------------------------------
// ntpc_pkg
// Shared types, constants and calendar helpers for the timestamp to date
// converter pipeline.
// ----------------------------------------------------------------------------
package ntpc_pkg;

	// pipeline depth, input register to output register
	localparam int unsigned NUM_STAGES = 7;

	localparam logic [10:0] EPOCH_YEAR = 11'd1900;

	// seconds per day and per estimated year, both with a common factor 2^7 removed
	localparam logic [9:0]  DAY_DIV    = 10'd675;
	localparam logic [22:0] DAY_RECIP  = 23'd6362914;  // floor(2^32 / 675)
	localparam logic [17:0] YEAR_DIV   = 18'd246537;
	localparam logic [14:0] YEAR_RECIP = 15'd17421;    // floor(2^32 / 246537)

	// time of day split
	localparam logic [11:0] HOUR_SECS     = 12'd3600;
	localparam logic [12:0] HOUR_RECIP    = 13'd4660;    // floor(2^24 / 3600)
	localparam logic [5:0]  MIN_SECS      = 6'd60;
	localparam logic [17:0] MIN_RECIP     = 18'd139810;  // floor(2^23 / 60)
	localparam logic [5:0]  MINS_PER_HOUR = 6'd60;

	// weekday
	localparam logic [2:0]  WEEK_DAYS  = 3'd7;
	localparam logic [16:0] WEEK_RECIP = 17'd74898;      // floor(2^19 / 7)

	// leap day handling
	localparam logic [8:0] LEAP_DAY   = 9'd59;
	localparam logic [3:0] MONTH_FEB  = 4'd2;
	localparam logic [4:0] LEAP_MDAY  = 5'd29;

	// first day of each month in a common year
	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

	// years since 1900, valid up to 199: 1900 is common, 2000 is leap
	function automatic logic is_leap(input logic [7:0] y);
		return (y[1:0] == 2'd0) && (y != 8'd0);
	endfunction

	// day number of january 1 of year 1900 + y; century terms cancel below 200
	function automatic logic [15:0] year_first_day(input logic [7:0] y);
		logic [15:0] base;
		base = 16'(y) * 16'd365 + 16'(y[7:2]);
		return base - 16'(is_leap(y));
	endfunction

endpackage

### rtl/core/ntpc_divide.sv
// ----------------------------------------------------------------------------
// ntpc_divide
// Stages 1 to 3: splits whole seconds into day count and time of day, and
// estimates the year, by reciprocal multiply and one-step correction.
// ----------------------------------------------------------------------------
module ntpc_divide import ntpc_pkg::*; (
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [31:0] secs,
	output logic [15:0] days_s3,
	output logic [16:0] tod_s3,
	output logic [7:0]  yest_s3
);

	logic [24:0] x;
	logic [47:0] day_prod;
	logic [39:0] year_prod;

	logic [24:0] x_s1;
	logic [6:0]  lo_s1;
	logic [15:0] qd_s1;
	logic [7:0]  qy_s1;

	logic [10:0] rd_s2;
	logic [18:0] ry_s2;
	logic [6:0]  lo_s2;
	logic [15:0] qd_s2;
	logic [7:0]  qy_s2;

	logic [24:0] day_back;
	logic [24:0] year_back;
	logic        day_over;
	logic [9:0]  rday;

	// quotient estimates, low by at most one
	assign x         = secs[31:7];
	assign day_prod  = 48'(x) * 48'(DAY_RECIP);
	assign year_prod = 40'(x) * 40'(YEAR_RECIP);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			x_s1  <= x;
			lo_s1 <= secs[6:0];
			qd_s1 <= day_prod[47:32];
			qy_s1 <= year_prod[39:32];
		end
	end

	// remainders against the estimates
	assign day_back  = x_s1 - 25'(26'(qd_s1) * 26'(DAY_DIV));
	assign year_back = x_s1 - 25'(26'(qy_s1) * 26'(YEAR_DIV));

	always_ff @(posedge clk) begin
		if (en.s2) begin
			rd_s2 <= day_back[10:0];
			ry_s2 <= year_back[18:0];
			lo_s2 <= lo_s1;
			qd_s2 <= qd_s1;
			qy_s2 <= qy_s1;
		end
	end

	// final correction
	assign day_over = rd_s2 >= 11'(DAY_DIV);
	assign rday     = day_over ? 10'(rd_s2 - 11'(DAY_DIV)) : rd_s2[9:0];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			days_s3 <= qd_s2 + 16'(day_over);
			tod_s3  <= {rday, lo_s2};
			yest_s3 <= qy_s2 + 8'(ry_s2 >= 19'(YEAR_DIV));
		end
	end

endmodule

### rtl/core/ntpc_days.sv
// ----------------------------------------------------------------------------
// ntpc_days
// Stages 4 to 6: resolves the exact year and day of year from the day
// count and the year estimate, and derives the weekday.
// ----------------------------------------------------------------------------
module ntpc_days import ntpc_pkg::*; (
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [15:0] days_s3,
	input  logic [7:0]  yest_s3,
	output logic [7:0]  y_s5,
	output logic [8:0]  yday_s5,
	output logic        leap_s5,
	output logic [2:0]  wd_s6
);

	logic [32:0] week_prod;

	logic [15:0] days_s4;
	logic [7:0]  yest_s4;
	logic [15:0] fd_lo_s4;
	logic [15:0] fd_mid_s4;
	logic [15:0] fd_hi_s4;
	logic [12:0] qw_s4;

	logic [7:0]  y_sel;
	logic [15:0] fd_sel;
	logic [15:0] week_back;
	logic [3:0]  rw_s5;

	// year start candidates and weekday quotient estimate
	assign week_prod = 33'(days_s3) * 33'(WEEK_RECIP);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			days_s4   <= days_s3;
			yest_s4   <= yest_s3;
			fd_lo_s4  <= year_first_day(yest_s3 - 8'd1);
			fd_mid_s4 <= year_first_day(yest_s3);
			fd_hi_s4  <= year_first_day(yest_s3 + 8'd1);
			qw_s4     <= week_prod[31:19];
		end
	end

	// move the estimate by at most one year
	always_comb begin
		if ((yest_s4 != 8'd0) && (days_s4 < fd_mid_s4)) begin
			y_sel  = yest_s4 - 8'd1;
			fd_sel = fd_lo_s4;
		end else if (days_s4 >= fd_hi_s4) begin
			y_sel  = yest_s4 + 8'd1;
			fd_sel = fd_hi_s4;
		end else begin
			y_sel  = yest_s4;
			fd_sel = fd_mid_s4;
		end
	end

	assign week_back = days_s4 - 16'(16'(qw_s4) * 16'(WEEK_DAYS));

	always_ff @(posedge clk) begin
		if (en.s5) begin
			y_s5    <= y_sel;
			yday_s5 <= 9'(days_s4 - fd_sel);
			leap_s5 <= is_leap(y_sel);
			rw_s5   <= week_back[3:0];
		end
	end

	// weekday, monday is 1
	always_ff @(posedge clk) begin
		if (en.s6) begin
			wd_s6 <= ((rw_s5 >= 4'(WEEK_DAYS)) ? 3'(rw_s5 - 4'(WEEK_DAYS)) : rw_s5[2:0]) + 3'd1;
		end
	end

endmodule

### rtl/core/ntpc_month.sv
// ----------------------------------------------------------------------------
// ntpc_month
// Stage 6: maps the day of year to month and day of month, with the leap
// day handled on its own, and forms the calendar year.
// ----------------------------------------------------------------------------
module ntpc_month import ntpc_pkg::*; (
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [7:0]  y_s5,
	input  logic [8:0]  yday_s5,
	input  logic        leap_s5,
	output logic [10:0] year_s6,
	output logic [3:0]  month_s6,
	output logic [4:0]  mday_s6
);

	logic [8:0] ydc;
	logic [3:0] mon;
	logic [3:0] mon_idx;
	logic [4:0] mday;

	// month table lookup
	always_comb begin
		ydc = (leap_s5 && (yday_s5 > LEAP_DAY)) ? yday_s5 - 9'd1 : yday_s5;
		mon = 4'd1;
		for (int i = 1; i < 12; i++) begin
			if (ydc >= MONTH_START[i]) begin
				mon = 4'(i + 1);
			end
		end
		mon_idx = mon - 4'd1;
		mday    = 5'(ydc - MONTH_START[mon_idx] + 9'd1);
		if (leap_s5 && (yday_s5 == LEAP_DAY)) begin
			mon  = MONTH_FEB;
			mday = LEAP_MDAY;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			year_s6  <= EPOCH_YEAR + 11'(y_s5);
			month_s6 <= mon;
			mday_s6  <= mday;
		end
	end

endmodule

### rtl/core/ntpc_clock.sv
// ----------------------------------------------------------------------------
// ntpc_clock
// Stages 4 to 6: splits the second of the day into hour, minute of the
// day and whole second.
// ----------------------------------------------------------------------------
module ntpc_clock import ntpc_pkg::*; (
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [16:0] tod_s3,
	output logic [4:0]  hour_s6,
	output logic [10:0] tmin_s6,
	output logic [5:0]  sec_s6
);

	logic [29:0] hour_prod;
	logic [34:0] min_prod;

	logic [16:0] tod_s4;
	logic [4:0]  qh_s4;
	logic [10:0] qm_s4;

	logic [16:0] hour_back;
	logic [16:0] min_back;
	logic [12:0] rh_s5;
	logic [6:0]  rm_s5;
	logic [4:0]  qh_s5;
	logic [10:0] qm_s5;

	logic        min_over;

	// quotient estimates for hours and minutes of the day
	assign hour_prod = 30'(tod_s3) * 30'(HOUR_RECIP);
	assign min_prod  = 35'(tod_s3) * 35'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			tod_s4 <= tod_s3;
			qh_s4  <= hour_prod[28:24];
			qm_s4  <= min_prod[33:23];
		end
	end

	// remainders
	assign hour_back = tod_s4 - 17'(17'(qh_s4) * 17'(HOUR_SECS));
	assign min_back  = tod_s4 - 17'(17'(qm_s4) * 17'(MIN_SECS));

	always_ff @(posedge clk) begin
		if (en.s5) begin
			rh_s5 <= hour_back[12:0];
			rm_s5 <= min_back[6:0];
			qh_s5 <= qh_s4;
			qm_s5 <= qm_s4;
		end
	end

	// one-step correction
	assign min_over = rm_s5 >= 7'(MIN_SECS);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			hour_s6 <= qh_s5 + 5'(rh_s5 >= 13'(HOUR_SECS));
			tmin_s6 <= qm_s5 + 11'(min_over);
			sec_s6  <= min_over ? 6'(rm_s5 - 7'(MIN_SECS)) : rm_s5[5:0];
		end
	end

endmodule

### rtl/core/ntp_stamp_to_calendar_date.sv
// ----------------------------------------------------------------------------
// ntp_stamp_to_calendar_date
// Converts a 32.32 NTP timestamp into UTC year, month, day, time of day,
// raw fraction and weekday.
//
//   channel | valid        | stall        | words
//   --------+--------------+--------------+------------------------------------
//   in      | stamp_valid  | stamp_stall  | stamp
//   out     | date_valid   | date_stall   | year, month, day_of_month, hour,
//           |              |              | minute, whole_second,
//           |              |              | second_fraction, day_of_week
//
// Seven register stages; one word enters per cycle while the pipeline is not stalled.
// Depth is set by the constant-reciprocal divisions, each taking a product
// stage, a remainder stage and a correction stage.
// Each stage holds while the next is full and stalled, so bubbles collapse.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module ntp_stamp_to_calendar_date import ntpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        stamp_valid,
	output logic        stamp_stall,
	input  logic [63:0] stamp,
	output logic        date_valid,
	input  logic        date_stall,
	output logic [10:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  whole_second,
	output logic [31:0] second_fraction,
	output logic [2:0]  day_of_week
);

	logic [NUM_STAGES:1] valid_q;
	logic [NUM_STAGES:1] load;
	stage_en_t           en;

	logic [31:0] frac_s1;
	logic [31:0] frac_s2;
	logic [31:0] frac_s3;
	logic [31:0] frac_s4;
	logic [31:0] frac_s5;
	logic [31:0] frac_s6;
	logic [31:0] frac_s7;

	logic [15:0] days_s3;
	logic [16:0] tod_s3;
	logic [7:0]  yest_s3;
	logic [7:0]  y_s5;
	logic [8:0]  yday_s5;
	logic        leap_s5;
	logic [2:0]  wd_s6;
	logic [10:0] year_s6;
	logic [3:0]  month_s6;
	logic [4:0]  mday_s6;
	logic [4:0]  hour_s6;
	logic [10:0] tmin_s6;
	logic [5:0]  sec_s6;

	logic [10:0] year_s7;
	logic [3:0]  month_s7;
	logic [4:0]  mday_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  minute_s7;
	logic [5:0]  sec_s7;
	logic [2:0]  wd_s7;

	// a stage loads when empty or when the stage after it moves on
	always_comb begin
		load[NUM_STAGES] = !valid_q[NUM_STAGES] || !date_stall;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			load[k] = !valid_q[k] || load[k + 1];
		end
	end

	assign en.s1 = load[1];
	assign en.s2 = load[2];
	assign en.s3 = load[3];
	assign en.s4 = load[4];
	assign en.s5 = load[5];
	assign en.s6 = load[6];
	assign en.s7 = load[7];

	assign stamp_stall = !load[1];

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[1]) begin
				valid_q[1] <= stamp_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k - 1];
				end
			end
		end
	end

	// fraction rides along untouched
	always_ff @(posedge clk) begin
		if (en.s1) begin
			frac_s1 <= stamp[31:0];
		end
		if (en.s2) begin
			frac_s2 <= frac_s1;
		end
		if (en.s3) begin
			frac_s3 <= frac_s2;
		end
		if (en.s4) begin
			frac_s4 <= frac_s3;
		end
		if (en.s5) begin
			frac_s5 <= frac_s4;
		end
		if (en.s6) begin
			frac_s6 <= frac_s5;
		end
		if (en.s7) begin
			frac_s7 <= frac_s6;
		end
	end

	// day count, time of day and year estimate
	ntpc_divide u_divide (
		.clk     (clk),
		.en      (en),
		.secs    (stamp[63:32]),
		.days_s3 (days_s3),
		.tod_s3  (tod_s3),
		.yest_s3 (yest_s3)
	);

	// exact year, day of year, weekday
	ntpc_days u_days (
		.clk     (clk),
		.en      (en),
		.days_s3 (days_s3),
		.yest_s3 (yest_s3),
		.y_s5    (y_s5),
		.yday_s5 (yday_s5),
		.leap_s5 (leap_s5),
		.wd_s6   (wd_s6)
	);

	// month and day of month
	ntpc_month u_month (
		.clk      (clk),
		.en       (en),
		.y_s5     (y_s5),
		.yday_s5  (yday_s5),
		.leap_s5  (leap_s5),
		.year_s6  (year_s6),
		.month_s6 (month_s6),
		.mday_s6  (mday_s6)
	);

	// hours, minutes of day, seconds
	ntpc_clock u_clock (
		.clk     (clk),
		.en      (en),
		.tod_s3  (tod_s3),
		.hour_s6 (hour_s6),
		.tmin_s6 (tmin_s6),
		.sec_s6  (sec_s6)
	);

	// output register, minute of hour taken from minute of day
	always_ff @(posedge clk) begin
		if (en.s7) begin
			year_s7   <= year_s6;
			month_s7  <= month_s6;
			mday_s7   <= mday_s6;
			hour_s7   <= hour_s6;
			minute_s7 <= 6'(tmin_s6 - 11'(11'(hour_s6) * 11'(MINS_PER_HOUR)));
			sec_s7    <= sec_s6;
			wd_s7     <= wd_s6;
		end
	end

	assign date_valid      = valid_q[NUM_STAGES];
	assign year            = year_s7;
	assign month           = month_s7;
	assign day_of_month    = mday_s7;
	assign hour            = hour_s7;
	assign minute          = minute_s7;
	assign whole_second    = sec_s7;
	assign second_fraction = frac_s7;
	assign day_of_week     = wd_s7;

endmodule

### bench/ntp_date_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_date_checker
// Watches both channels of the timestamp to date converter. It works out
// the calendar date of every accepted stamp word and compares each
// accepted date word, field by field, against the oldest one still owed.
// ----------------------------------------------------------------------------
module ntp_date_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        stamp_valid,
	input  logic        stamp_stall,
	input  logic [63:0] stamp,
	input  logic        date_valid,
	input  logic        date_stall,
	input  logic [10:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day_of_month,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  whole_second,
	input  logic [31:0] second_fraction,
	input  logic [2:0]  day_of_week,
	output int          mismatches,
	output int          dates_owed
);

	localparam int unsigned DAY_SECS      = 86400;
	localparam int unsigned EST_YEAR_SECS = 31556736;  // 365.24 days
	localparam int unsigned BASE_YEAR     = 1900;

	typedef struct packed {
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [31:0] fraction;
		logic [2:0]  weekday;
	} date_t;

	date_t owed_dates [$];

	// gregorian rule on the full year number
	function automatic bit leap_year(input int unsigned yrs);
		int unsigned full_year;
		full_year = yrs + BASE_YEAR;
		return (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
	endfunction

	// leap years up to and including a given year, counted from year 0
	function automatic int unsigned leaps_up_to(input int unsigned full_year);
		return full_year / 4 - full_year / 100 + full_year / 400;
	endfunction

	// days from 1900-01-01 to january 1 of 1900 + yrs
	function automatic int unsigned jan1_day(input int unsigned yrs);
		return 365 * yrs + leaps_up_to(BASE_YEAR + yrs - 1) - leaps_up_to(BASE_YEAR - 1);
	endfunction

	// day of year where a month starts, common year
	function automatic int unsigned month_first_day(input int unsigned mon);
		case (mon)
			1:       return 0;
			2:       return 31;
			3:       return 59;
			4:       return 90;
			5:       return 120;
			6:       return 151;
			7:       return 181;
			8:       return 212;
			9:       return 243;
			10:      return 273;
			11:      return 304;
			default: return 334;
		endcase
	endfunction

	// full conversion of one stamp word
	function automatic date_t stamp_to_date(input logic [63:0] value);
		int unsigned secs, days, tod, yrs, yday, mon, mday;
		date_t d;
		secs = value[63:32];
		days = secs / DAY_SECS;
		tod  = secs % DAY_SECS;

		// rough year, then pull it onto the true year start
		yrs = secs / EST_YEAR_SECS;
		if (yrs > 0 && days < jan1_day(yrs))
			yrs = yrs - 1;
		else if (days >= jan1_day(yrs + 1))
			yrs = yrs + 1;
		yday = days - jan1_day(yrs);

		// leap day stands apart, later days of a leap year slide back one
		if (leap_year(yrs) && yday == 59) begin
			mon  = 2;
			mday = 29;
		end else begin
			if (leap_year(yrs) && yday > 59)
				yday = yday - 1;
			mon = 1;
			for (int m = 2; m <= 12; m++) begin
				if (yday >= month_first_day(m))
					mon = m;
			end
			mday = yday - month_first_day(mon) + 1;
		end

		d.year     = 11'(yrs + BASE_YEAR);
		d.month    = 4'(mon);
		d.mday     = 5'(mday);
		d.hour     = 5'(tod / 3600);
		d.minute   = 6'((tod % 3600) / 60);
		d.second   = 6'(tod % 60);
		d.fraction = value[31:0];
		d.weekday  = 3'(1 + days % 7);
		return d;
	endfunction

	task automatic compare_field(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	initial begin
		mismatches = 0;
		dates_owed = 0;
	end

	// retire date words first, then log new stamp words
	always @(posedge clk) begin
		date_t want;
		if (arst_n) begin
			if (date_valid && !date_stall) begin
				if (owed_dates.size() == 0) begin
					mismatches++;
					$display("%0t: date word with none expected, got %0d-%0d-%0d %0d:%0d:%0d",
						$time, year, month, day_of_month, hour, minute, whole_second);
				end else begin
					want = owed_dates.pop_front();
					compare_field("year", want.year, year);
					compare_field("month", want.month, month);
					compare_field("day_of_month", want.mday, day_of_month);
					compare_field("hour", want.hour, hour);
					compare_field("minute", want.minute, minute);
					compare_field("whole_second", want.second, whole_second);
					compare_field("second_fraction", want.fraction, second_fraction);
					compare_field("day_of_week", want.weekday, day_of_week);
				end
			end
			if (stamp_valid && !stamp_stall)
				owed_dates.push_back(stamp_to_date(stamp));
			dates_owed = owed_dates.size();
		end
	end

endmodule

### bench/tb_ntp_stamp_to_calendar_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntp_stamp_to_calendar_date
// Drives stamp words into the converter: year edges, leap days and field
// extremes first, then random stamps biased toward the points where the
// rough year estimate needs correcting. Both sides idle at random, the
// output side also holds off long enough to back up the pipeline. The
// checker beside the converter does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_ntp_stamp_to_calendar_date;
	import ntpc_pkg::NUM_STAGES;

	localparam int unsigned DAY_SECS      = 86400;
	localparam int unsigned EST_YEAR_SECS = 31556736;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned HOLD_CYCLES   = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        stamp_valid = 1'b0;
	logic        stamp_stall;
	logic [63:0] stamp = '0;
	logic        date_valid;
	logic        date_stall = 1'b0;
	logic [10:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  whole_second;
	logic [31:0] second_fraction;
	logic [2:0]  day_of_week;

	int          mismatches;
	int          dates_owed;
	int          gap_pct = 17;
	int          stall_pct = 81;
	bit          hold_req = 1'b0;
	int unsigned cycle_count = 0;

	ntp_stamp_to_calendar_date dut (.*);

	ntp_date_checker date_chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[ntp_stamp_to_calendar_date] ERROR");
			$finish;
		end
	end

	// output side stall, with a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				date_stall <= 1'b1;
				hold_left--;
			end else begin
				date_stall <= (int'($urandom_range(99)) < stall_pct);
			end
		end
	end

	// offer one stamp word, after a random gap, and wait for it to be taken
	task automatic send_stamp(input logic [63:0] value);
		while (int'($urandom_range(99)) < gap_pct) begin
			stamp_valid <= 1'b0;
			@(negedge clk);
		end
		stamp_valid <= 1'b1;
		stamp <= value;
		@(posedge clk);
		while (stamp_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// last second of the old year and first second of the new one
	task automatic send_year_edge(input int unsigned first_day);
		send_stamp({32'(first_day * DAY_SECS - 1), 32'($urandom)});
		send_stamp({32'(first_day * DAY_SECS), 32'($urandom)});
	endtask

	// stamp around a given day, anywhere in that day
	function automatic logic [63:0] stamp_in_day(input int unsigned day);
		return {32'(day * DAY_SECS + $urandom_range(DAY_SECS - 1)), 32'($urandom)};
	endfunction

	function automatic logic [63:0] random_stamp();
		int unsigned pick, k, tod;
		logic [31:0] secs;
		pick = $urandom_range(99);
		if (pick < 40) begin
			secs = $urandom;
		end else if (pick < 70) begin
			// a few days either side of an estimated year start
			k = $urandom_range(136, 1);
			secs = 32'(k * EST_YEAR_SECS - 3 * DAY_SECS + $urandom_range(6 * DAY_SECS));
		end else if (pick < 90) begin
			// around february 29 of every fourth year, 1900 included
			k = 4 * $urandom_range(33);
			secs = 32'(k * EST_YEAR_SECS + (56 + $urandom_range(6)) * DAY_SECS
				+ $urandom_range(DAY_SECS - 1));
		end else begin
			// time of day at its corners
			case ($urandom_range(3))
				0:       tod = 0;
				1:       tod = 59;
				2:       tod = 3599;
				default: tod = DAY_SECS - 1;
			endcase
			secs = 32'($urandom_range(49709) * DAY_SECS + tod);
		end
		return {secs, 32'($urandom)};
	endfunction

	// stimulus and verdict
	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// field extremes and bit patterns
		send_stamp(64'h0);
		send_stamp('1);
		send_stamp(64'h0000_0000_FFFF_FFFF);
		send_stamp(64'hFFFF_FFFF_0000_0000);
		send_stamp(64'hAAAA_AAAA_5555_5555);
		send_stamp(64'h5555_5555_AAAA_AAAA);

		// year starts of 1901, 1904, 1905, 2000, 2001 and 2036
		send_year_edge(365);
		send_year_edge(1460);
		send_year_edge(1826);
		send_year_edge(36524);
		send_year_edge(36890);
		send_year_edge(49673);

		// march 1 1900 with no leap day, then around the 1904 and 2000 leap days
		send_stamp(stamp_in_day(59));
		send_stamp(stamp_in_day(1518));
		send_stamp(stamp_in_day(1519));
		send_stamp(stamp_in_day(1520));
		send_stamp(stamp_in_day(36583));
		send_stamp(stamp_in_day(36584));

		// random part in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				gap_pct = 81;
				stall_pct = 17;
			end else if (ph == 2) begin
				gap_pct = 0;
				stall_pct = 0;
				hold_req = 1'b1;
			end
			repeat (ph == 2 ? 190 : 180)
				send_stamp(random_stamp());
		end
		stamp_valid <= 1'b0;

		// drain
		while (dates_owed != 0)
			@(negedge clk);
		repeat (4 * NUM_STAGES) @(negedge clk);

		if (mismatches == 0)
			$display("[ntp_stamp_to_calendar_date] OK");
		else
			$display("[ntp_stamp_to_calendar_date] ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/core/ntpc_pkg.sv
rtl/core/ntpc_divide.sv
rtl/core/ntpc_days.sv
rtl/core/ntpc_month.sv
rtl/core/ntpc_clock.sv
rtl/core/ntp_stamp_to_calendar_date.sv
bench/ntp_date_checker.sv
bench/tb_ntp_stamp_to_calendar_date.sv
